// File: rtl/assert_macros.svh
// Shared assertion wrappers for the serial frame receiver checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int BUF_DEPTH  = 256;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);
  localparam int LEN_W      = $clog2(BUF_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0] CMD_BYTE     = 3'd0;
  localparam logic [2:0] CMD_TICK     = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_RELEASE  = 3'd3;
  localparam logic [2:0] CMD_TX_BEGIN = 3'd4;
  localparam logic [2:0] CMD_TX_END   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEVEN_BIT_DATA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 3'd4;

  localparam logic MODE_DELIMITED = 1'b0;
  localparam logic MODE_RTU       = 1'b1;

  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] BROADCAST = 8'h7F;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] length;
  } frame_state_t;

endpackage

// File: rtl/sfr_req_if.sv
interface sfr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] byte_value;
  logic [7:0] read_index;

  modport source (output valid, command, byte_value, read_index, input ready);
  modport sink (input valid, command, byte_value, read_index, output ready);
endinterface

// File: rtl/sfr_rsp_if.sv
interface sfr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [8:0] frame_length;
  logic [7:0] read_data;

  modport source (output valid, frame_status, frame_length, read_data, input ready);
  modport sink (input valid, frame_status, frame_length, read_data, output ready);
endinterface

// File: rtl/sfr_ram.sv
module sfr_ram (
  input  logic                      clk,
  input  sfr_pkg::mem_req_t         req,
  output logic [7:0]                rdata
);

  logic [7:0] mem [sfr_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: rtl/sfr_ctrl.sv
module sfr_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             go,
  input  logic [2:0]                       command,
  input  logic [7:0]                       byte_value,
  input  logic [7:0]                       read_index,
  output sfr_pkg::mem_req_t                mem_req,
  output logic                             is_read,
  output sfr_pkg::frame_state_t            state
);

  logic        protocol_mode;
  logic [7:0]  device_address;
  logic [7:0]  address_offset;
  logic        seven_bit_data;
  logic [15:0] gap_ticks;

  sfr_pkg::phase_t                phase, phase_next;
  logic [sfr_pkg::LEN_W-1:0]      wp, wp_next;
  logic [15:0]                    timer, timer_next;
  logic                           echo, echo_next;
  logic [7:0]                     byte0, byte1;

  logic [7:0]  b;
  logic [7:0]  own;
  logic [7:0]  addr_byte;
  logic [15:0] reload;
  logic        has_room;

  assign own      = address_offset + device_address;
  assign reload   = (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
  assign has_room = wp < sfr_pkg::LEN_W'(sfr_pkg::BUF_DEPTH);
  assign b        = (protocol_mode == sfr_pkg::MODE_DELIMITED && seven_bit_data)
                    ? {1'b0, byte_value[6:0]} : byte_value;
  assign addr_byte = (wp == sfr_pkg::LEN_W'(1)) ? b : byte1;

  always_comb begin
    phase_next    = phase;
    wp_next       = wp;
    timer_next    = timer;
    echo_next     = echo;
    mem_req       = '0;
    mem_req.wdata = b;
    mem_req.raddr = sfr_pkg::BUF_AW'(read_index);
    is_read       = 1'b0;
    if (go) begin
      case (command)
        sfr_pkg::CMD_BYTE: begin
          if (protocol_mode == sfr_pkg::MODE_DELIMITED) begin
            if (b == sfr_pkg::CH_ETX) begin
              echo_next = 1'b0;
            end
            if (!echo_next) begin
              if (b == sfr_pkg::CH_STX) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                wp_next       = sfr_pkg::LEN_W'(1);
                phase_next    = sfr_pkg::PH_COLLECT;
              end else if (phase == sfr_pkg::PH_COLLECT && has_room) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wp[sfr_pkg::BUF_AW-1:0];
                wp_next       = wp + sfr_pkg::LEN_W'(1);
                if (b == sfr_pkg::CH_ETX) begin
                  phase_next = (addr_byte == own || addr_byte == sfr_pkg::BROADCAST)
                               ? sfr_pkg::PH_DONE : sfr_pkg::PH_IDLE;
                end
              end else if (phase != sfr_pkg::PH_DONE) begin
                phase_next = sfr_pkg::PH_IDLE;
                timer_next = '0;
              end
            end
          end else if (!echo) begin
            if (phase == sfr_pkg::PH_IDLE) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = '0;
              wp_next       = sfr_pkg::LEN_W'(1);
              phase_next    = sfr_pkg::PH_COLLECT;
              timer_next    = reload;
            end else if (phase == sfr_pkg::PH_COLLECT && has_room) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = wp[sfr_pkg::BUF_AW-1:0];
              wp_next       = wp + sfr_pkg::LEN_W'(1);
              timer_next    = reload;
            end else if (phase != sfr_pkg::PH_DONE) begin
              phase_next = sfr_pkg::PH_IDLE;
              timer_next = '0;
            end
          end
        end
        sfr_pkg::CMD_TICK: begin
          if (timer != 16'd0) begin
            timer_next = timer - 16'd1;
            if (timer == 16'd1 && protocol_mode == sfr_pkg::MODE_RTU &&
                phase == sfr_pkg::PH_COLLECT) begin
              phase_next = (byte0 == device_address || byte0 == 8'd0)
                           ? sfr_pkg::PH_DONE : sfr_pkg::PH_IDLE;
            end
          end
        end
        sfr_pkg::CMD_READ: begin
          if (sfr_pkg::LEN_W'(read_index) < sfr_pkg::LEN_W'(sfr_pkg::BUF_DEPTH)) begin
            mem_req.re = 1'b1;
            is_read    = 1'b1;
          end
        end
        sfr_pkg::CMD_RELEASE: begin
          phase_next = sfr_pkg::PH_IDLE;
          wp_next    = '0;
          timer_next = '0;
        end
        sfr_pkg::CMD_TX_BEGIN: echo_next = 1'b1;
        sfr_pkg::CMD_TX_END:   echo_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfr_pkg::PH_IDLE;
      wp             <= '0;
      timer          <= '0;
      echo           <= 1'b0;
      protocol_mode  <= sfr_pkg::MODE_RTU;
      device_address <= 8'd1;
      address_offset <= 8'd32;
      seven_bit_data <= 1'b0;
      gap_ticks      <= 16'd4;
    end else begin
      phase <= phase_next;
      wp    <= wp_next;
      timer <= timer_next;
      echo  <= echo_next;
      if (cfg_write) begin
        case (cfg_index)
          sfr_pkg::REG_PROTOCOL_MODE:  protocol_mode  <= cfg_data[0];
          sfr_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
          sfr_pkg::REG_ADDRESS_OFFSET: address_offset <= cfg_data[7:0];
          sfr_pkg::REG_SEVEN_BIT_DATA: seven_bit_data <= cfg_data[0];
          sfr_pkg::REG_GAP_TICKS:      gap_ticks      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // mirror the two address bytes so frame decisions need no buffer read
  always_ff @(posedge clk) begin
    if (mem_req.we && mem_req.waddr == sfr_pkg::BUF_AW'(0)) begin
      byte0 <= mem_req.wdata;
    end
    if (mem_req.we && mem_req.waddr == sfr_pkg::BUF_AW'(1)) begin
      byte1 <= mem_req.wdata;
    end
  end

  assign state.phase  = phase;
  assign state.length = wp;

endmodule

// File: rtl/serial_frame_receiver.sv
// Serial frame receiver.
// req channel: one command per transfer (byte received, tick, read buffer,
//   release frame, transmit begins, transmit ends) with byte_value and
//   read_index.
// rsp channel: exactly one result per command, in order: frame_status and
//   frame_length after the command, and read_data for a buffer read, else 0.
// cfg port: cfg_write with cfg_index 0..4 (protocol_mode, device_address,
//   address_offset, seven_bit_data, gap_ticks); write only while idle.
// Pipeline: a command's result passes the s1 stage, then the output register, before it is offered.
// Throughput: one command per cycle while req.ready is high; the frame buffer is a
//   256 x 8 memory with separate write and read addresses, used for one write or one registered read per command.
// Reset: synchronous; frame idle, length 0, echo suppression off, registers
//   back to their defaults. The buffer is not cleared.
// Stall: results queue in a two-deep pipeline; req.ready drops once both
//   stages are full and rsp.ready is low, and no result is lost.
module serial_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  sfr_req_if.sink                          req,
  sfr_rsp_if.source                        rsp,
  input  logic                             cfg_write,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sfr_pkg::mem_req_t     mem_req;
  sfr_pkg::frame_state_t state;
  logic [7:0]            rdata;
  logic                  is_read;
  logic                  go;
  logic                  advance;
  logic                  s1_valid;
  logic                  s1_read;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [sfr_pkg::LEN_W-1:0] out_length;
  logic [7:0]            out_read;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign go        = req.valid && req.ready;

  sfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .go         (go),
    .command    (req.command),
    .byte_value (req.byte_value),
    .read_index (req.read_index),
    .mem_req    (mem_req),
    .is_read    (is_read),
    .state      (state)
  );

  sfr_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // hold frame state and read data of the pending item until it moves on
  always_ff @(posedge clk) begin
    if (go) begin
      s1_read <= is_read;
    end
    if (advance && s1_valid) begin
      out_status <= state.phase;
      out_length <= state.length;
      out_read   <= s1_read ? rdata : 8'd0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_status = out_status;
  assign rsp.frame_length = out_length;
  assign rsp.read_data    = out_read;

endmodule

// File: rtl/sfr_checker.sv
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] frame_status,
  input logic [8:0] frame_length,
  input logic [7:0] read_data
);

  `SFR_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result offered right after reset")
  `SFR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_status) && $stable(frame_length) && $stable(read_data), "stalled result changed")
  `SFR_ASSERT(a_collect_len, rsp_valid && frame_status == 2'd1 |-> frame_length != 9'd0 && frame_length <= 9'd256, "collecting frame with bad length")
  `SFR_ASSERT(a_no_result_lag, !rsp_valid && !req_ready |-> 1'b0, "input stalled while no result waits")

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .frame_status (rsp.frame_status),
  .frame_length (rsp.frame_length),
  .read_data    (rsp.read_data)
);
